FILE: rtl/core/thermistor_adc_to_celsius_defines.svh
// ----------------------------------------------------------------------------
// Thermistor ADC to Celsius - assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_ADC_TO_CELSIUS_DEFINES_SVH
`define THERMISTOR_ADC_TO_CELSIUS_DEFINES_SVH

// same-cycle implication
`define TAC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tac: implication check failed");

// next-cycle implication
`define TAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tac: next-cycle check failed");

`endif

FILE: rtl/core/tac_pkg.sv
// ----------------------------------------------------------------------------
// Thermistor ADC to Celsius - package
// Breakpoint table, widths and the reciprocal used for the segment divide.
// ----------------------------------------------------------------------------
package tac_pkg;

  localparam int TABULATED     = 20;
  localparam int TABLE_ENTRIES = 20;
  localparam int ADC_W         = 10;
  localparam int TEMP_W        = 8;
  localparam int BPT_W         = 10;
  localparam int IDX_W         = $clog2(TABULATED);
  localparam int NUM_W         = 16;
  localparam int MAG_W         = NUM_W - 1;

  localparam logic [TEMP_W-1:0] TEMP_SAT = 8'd255;

  // Breakpoints are evenly spaced, so every segment divides by the same span.
  localparam int SPAN        = 53;
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_W     = 16;
  // ceil(2^21 / 53); exact for any numerator below 2^15
  localparam logic [RECIP_W-1:0] RECIP_MUL = 16'd39569;
  localparam int PROD_W = MAG_W + RECIP_W;
  localparam int QUO_W  = PROD_W - RECIP_SHIFT;

  localparam logic [ADC_W-1:0] BP_ADC [TABULATED] = '{
    10'd1,   10'd54,  10'd107, 10'd160, 10'd213, 10'd266, 10'd319,
    10'd372, 10'd425, 10'd478, 10'd531, 10'd584, 10'd637, 10'd690,
    10'd743, 10'd796, 10'd849, 10'd902, 10'd955, 10'd1008
  };

  localparam logic [BPT_W-1:0] BP_TEMP [TABULATED] = '{
    10'd841, 10'd255, 10'd209, 10'd184, 10'd166, 10'd153, 10'd142,
    10'd132, 10'd124, 10'd116, 10'd108, 10'd101, 10'd93,  10'd86,
    10'd78,  10'd70,  10'd61,  10'd50,  10'd34,  10'd3
  };

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } seg_t;

endpackage

FILE: rtl/core/tac_seg_search.sv
// ----------------------------------------------------------------------------
// Thermistor ADC to Celsius - segment search
// Parallel compare against all breakpoints but the first, picks the first
// one above the reading.
// ----------------------------------------------------------------------------
module tac_seg_search #(
  parameter int TABLE_ENTRIES = tac_pkg::TABLE_ENTRIES
) (
  input  logic [tac_pkg::ADC_W-1:0] reading_i,
  output tac_pkg::seg_t             seg_o
);

  localparam int Limit = (TABLE_ENTRIES > tac_pkg::TABULATED) ?
                         tac_pkg::TABULATED : TABLE_ENTRIES;

  always_comb begin
    seg_o = '0;
    // scan downward so the lowest hit wins
    for (int k = Limit - 1; k >= 1; k--) begin
      if (tac_pkg::BP_ADC[k] > reading_i) begin
        seg_o.found = 1'b1;
        seg_o.idx   = tac_pkg::IDX_W'(k);
      end
    end
  end

endmodule

FILE: rtl/core/thermistor_adc_to_celsius.sv
// ----------------------------------------------------------------------------
// Thermistor ADC to Celsius - top level
// Breakpoint lookup with linear interpolation, four-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one 10-bit thermistor ADC sample per transfer and returns the
// temperature in whole degrees C, saturated at 255; readings below the first
// segment or at/above the last breakpoint give 255. Throughput is one sample
// per clock while the output is not stalled; each sample passes through four
// register stages (search, slope multiply, reciprocal multiply, round/clamp
// into the output register). Per-stage valid bits with a ready chain let
// bubbles collapse under backpressure.
module thermistor_adc_to_celsius #(
  parameter int TABLE_ENTRIES = tac_pkg::TABLE_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] adc_reading, [15:10] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [7:0] temperature_c
);

  localparam int IDX_W = tac_pkg::IDX_W;

  logic v1_q, v2_q, v3_q, vo_q;
  logic v1_d, v2_d, v3_d, vo_d;
  logic rdy1, rdy2, rdy3, rdyo;

  assign rdyo = !vo_q || m_axis_tready;
  assign rdy3 = !v3_q || rdyo;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  // stage 1: segment search
  tac_pkg::seg_t seg;
  tac_pkg::seg_t s1_seg_q;
  logic [tac_pkg::ADC_W-1:0] s1_rd_q;

  tac_seg_search #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_search (
    .reading_i (s_axis_tdata[tac_pkg::ADC_W-1:0]),
    .seg_o     (seg)
  );

  // stage 2: offset * slope rise
  logic [IDX_W-1:0]           prev_idx;
  logic signed [10:0]         off;
  logic signed [10:0]         rise;
  logic signed [21:0]         num_full;
  logic signed [tac_pkg::NUM_W-1:0] s2_num_q;
  logic [tac_pkg::BPT_W-1:0]  s2_tprev_q;
  logic                       s2_found_q;

  assign prev_idx = s1_seg_q.idx - IDX_W'(1);
  assign off  = $signed({1'b0, s1_rd_q}) - $signed({1'b0, tac_pkg::BP_ADC[prev_idx]});
  assign rise = $signed({1'b0, tac_pkg::BP_TEMP[s1_seg_q.idx]})
              - $signed({1'b0, tac_pkg::BP_TEMP[prev_idx]});
  assign num_full = off * rise;

  // stage 3: magnitude times reciprocal of the span
  logic [tac_pkg::MAG_W-1:0]  mag;
  logic [tac_pkg::PROD_W-1:0] s3_prod_q;
  logic                       s3_neg_q;
  logic [tac_pkg::BPT_W-1:0]  s3_tprev_q;
  logic                       s3_found_q;

  assign mag = s2_num_q[tac_pkg::NUM_W-1] ? tac_pkg::MAG_W'(-s2_num_q)
                                          : s2_num_q[tac_pkg::MAG_W-1:0];

  // stage 4: quotient, add, clamp
  logic [tac_pkg::QUO_W-1:0] quo;
  logic signed [11:0]        sum;
  logic [tac_pkg::TEMP_W-1:0] temp_d;
  logic [tac_pkg::TEMP_W-1:0] temp_q;

  assign quo = s3_prod_q[tac_pkg::PROD_W-1:tac_pkg::RECIP_SHIFT];

  always_comb begin
    // truncation toward zero: divide the magnitude, then restore the sign
    if (s3_neg_q) begin
      sum = $signed({2'b00, s3_tprev_q}) - $signed({2'b00, quo});
    end else begin
      sum = $signed({2'b00, s3_tprev_q}) + $signed({2'b00, quo});
    end
    if (!s3_found_q) begin
      temp_d = tac_pkg::TEMP_SAT;
    end else if (sum < 0) begin
      temp_d = '0;
    end else if (sum > $signed({4'b0000, tac_pkg::TEMP_SAT})) begin
      temp_d = tac_pkg::TEMP_SAT;
    end else begin
      temp_d = sum[tac_pkg::TEMP_W-1:0];
    end
  end

  always_comb begin
    v1_d = rdy1 ? s_axis_tvalid : v1_q;
    v2_d = rdy2 ? v1_q : v2_q;
    v3_d = rdy3 ? v2_q : v3_q;
    vo_d = rdyo ? v3_q : vo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      vo_q <= vo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_seg_q <= seg;
      s1_rd_q  <= s_axis_tdata[tac_pkg::ADC_W-1:0];
    end
    if (rdy2) begin
      s2_num_q   <= num_full[tac_pkg::NUM_W-1:0];
      s2_tprev_q <= tac_pkg::BP_TEMP[prev_idx];
      s2_found_q <= s1_seg_q.found;
    end
    if (rdy3) begin
      s3_prod_q  <= tac_pkg::PROD_W'(mag) * tac_pkg::PROD_W'(tac_pkg::RECIP_MUL);
      s3_neg_q   <= s2_num_q[tac_pkg::NUM_W-1];
      s3_tprev_q <= s2_tprev_q;
      s3_found_q <= s2_found_q;
    end
    if (rdyo) begin
      temp_q <= temp_d;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = temp_q;

endmodule

FILE: rtl/core/tac_checker.sv
// ----------------------------------------------------------------------------
// Thermistor ADC to Celsius - port checker
// Port-level assertions on flow and saturation, bound to the top level.
// ----------------------------------------------------------------------------
`include "thermistor_adc_to_celsius_defines.svh"

module tac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  logic in_xfer;
  logic out_of_range;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  // below the first segment or at/above the last breakpoint
  assign out_of_range =
    (s_axis_tdata[tac_pkg::ADC_W-1:0] < tac_pkg::BP_ADC[1]) ||
    (s_axis_tdata[tac_pkg::ADC_W-1:0] >= tac_pkg::BP_ADC[tac_pkg::TABULATED-1]);

  `TAC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))

  `TAC_ASSERT_IMPLY(a_no_bubble_stall, m_axis_tready, s_axis_tready)

  `TAC_ASSERT_NEXT(a_latency, in_xfer ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready,
                   m_axis_tvalid)

  `TAC_ASSERT_NEXT(a_saturate,
                   (in_xfer && out_of_range) ##1 m_axis_tready ##1 m_axis_tready
                     ##1 m_axis_tready,
                   m_axis_tvalid && (m_axis_tdata == tac_pkg::TEMP_SAT))

endmodule

bind thermistor_adc_to_celsius tac_checker u_tac_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: test/tb_thermistor_adc_to_celsius.sv
// ----------------------------------------------------------------------------
// Thermistor ADC to Celsius - testbench
// Feeds ADC samples over the input stream and checks each temperature against
// an in-bench breakpoint interpolation, with bursty input and output stalls.
// ----------------------------------------------------------------------------
module tb_thermistor_adc_to_celsius;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KNOTS       = 20;
  localparam int TEMP_MAX    = 255;
  localparam int N_DIRECTED  = 22;
  localparam int N_RANDOM    = 1000;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_AFTER  = 200;
  localparam int PREDICT     = -1;   // table row whose temperature comes from the predictor

  localparam int ADC_KNOT [KNOTS] = '{
    1,   54,  107, 160, 213, 266, 319, 372, 425, 478,
    531, 584, 637, 690, 743, 796, 849, 902, 955, 1008
  };
  localparam int TEMP_KNOT [KNOTS] = '{
    841, 255, 209, 184, 166, 153, 142, 132, 124, 116,
    108, 101, 93,  86,  78,  70,  61,  50,  34,  3
  };

  // directed samples; temperatures typed in only where obvious
  localparam int DIR_ADC [N_DIRECTED] = '{
    0,    1,    2,    53,   54,   55,   106,  107,  341,  500,  512,
    531,  682,  955,  956,  1007, 1008, 1009, 1022, 1023, 341,  682
  };
  localparam int DIR_TEMP [N_DIRECTED] = '{
    255,     255,     PREDICT, PREDICT, 255,     PREDICT, PREDICT, 209,
    PREDICT, PREDICT, PREDICT, 108,     PREDICT, 34,      PREDICT, PREDICT,
    255,     255,     255,     255,     PREDICT, PREDICT
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [9:0] adc_reading, [15:10] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] temperature_c

  logic [7:0] temp_q [$];
  int err_cnt;
  int sent_cnt;
  int checked_cnt;
  int idle_cyc;
  int burst_left;

  thermistor_adc_to_celsius u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // first knot strictly above the reading, interpolate from the one below
  function automatic logic [7:0] celsius_from_adc(input logic [9:0] reading);
    int r;
    int t;
    bit hit;
    r   = int'(reading);
    t   = TEMP_MAX;
    hit = 1'b0;
    for (int k = 1; k < KNOTS; k++) begin
      if (!hit && ADC_KNOT[k] > r) begin
        hit = 1'b1;
        t = TEMP_KNOT[k-1] + ((r - ADC_KNOT[k-1]) * (TEMP_KNOT[k] - TEMP_KNOT[k-1]))
            / (ADC_KNOT[k] - ADC_KNOT[k-1]);
        if (t > TEMP_MAX) t = TEMP_MAX;
        if (t < 0) t = 0;
      end
    end
    return t[7:0];
  endfunction

  // offer one sample, hold it until the transfer, then maybe open a gap
  task automatic send_sample(input logic [9:0] reading, input int want_c);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, reading};
    do @(posedge clk_i); while (!s_axis_tready);
    temp_q.push_back(want_c == PREDICT ? celsius_from_adc(reading) : 8'(want_c));
    sent_cnt++;
    burst_left--;
    if (burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
    end
  endtask

  // receiver: random stall pattern per phase, one long hold-off
  initial begin
    int mode;
    int phase_cyc;
    int hold_left;
    bit hold_done;
    mode      = 0;
    phase_cyc = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (phase_cyc == 0) begin
        mode      = $urandom_range(0, 3);
        phase_cyc = 50;
      end
      phase_cyc--;
      if (!hold_done && checked_cnt >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= (phase_cyc % 3 == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (temp_q.size() == 0) begin
          $error("unexpected result: temperature_c %0d", m_axis_tdata);
          err_cnt++;
        end else begin
          logic [7:0] want;
          want = temp_q.pop_front();
          if (m_axis_tdata !== want) begin
            $error("temperature_c mismatch: expected %0d, got %0d", want, m_axis_tdata);
            err_cnt++;
          end
          checked_cnt++;
        end
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cyc = 0;
      else
        idle_cyc++;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [9:0] reading;
    int pick;
    int k;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    err_cnt       = 0;
    sent_cnt      = 0;
    checked_cnt   = 0;
    idle_cyc      = 0;
    burst_left    = $urandom_range(1, 10);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++)
      send_sample(10'(DIR_ADC[i]), DIR_TEMP[i]);

    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        reading = 10'($urandom_range(0, 1023));
      end else if (pick < 85) begin
        // hug a breakpoint from either side
        k = $urandom_range(0, KNOTS - 1);
        reading = 10'(ADC_KNOT[k] + $urandom_range(0, 4) - 2);
      end else if (pick < 93) begin
        reading = 10'($urandom_range(1000, 1023));
      end else begin
        reading = 10'($urandom_range(0, 3));
      end
      send_sample(reading, PREDICT);
    end

    s_axis_tvalid <= 1'b0;
    while (temp_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d samples (%0d directed, rest random near knots and ends);",
             sent_cnt, N_DIRECTED);
    $display("checked %0d temperatures under bursty input and output stalls.", checked_cnt);
    if (err_cnt == 0 && temp_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: thermistor_adc_to_celsius.f
+incdir+rtl/core
rtl/core/tac_pkg.sv
rtl/core/tac_seg_search.sv
rtl/core/thermistor_adc_to_celsius.sv
rtl/core/tac_checker.sv
test/tb_thermistor_adc_to_celsius.sv
